@@ design/ilid_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ilid_pkg;

  // Field widths of one beat
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int IDX_W  = 9;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 7;

  // Default list depth
  localparam int CAPACITY_DEF = 64;

  // Taps folded per first-level group of the read tree
  localparam int GROUP = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
  localparam logic [OP_W-1:0] OP_BEFORE = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_BADIDX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } cell_op_t;

endpackage

`default_nettype wire

@@ design/ilid_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ilid_cell import ilid_pkg::*; #(
  parameter int PW  = 6,
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire cell_op_t          cop,
  input  wire logic [PW-1:0]     pos,
  input  wire logic [DATA_W-1:0] value,
  input  wire logic [DATA_W-1:0] left,
  input  wire logic [DATA_W-1:0] right,
  output logic      [DATA_W-1:0] data,
  output logic      [DATA_W-1:0] tap
);

  localparam logic [PW-1:0] POS = PW'(IDX);

  // Entry: shift toward the tail on insert, toward the head on delete
  always_ff @(posedge clk) begin
    if (cop.ins) begin
      if (POS > pos) begin
        data <= left;
      end else if (POS == pos) begin
        data <= value;
      end
    end else if (cop.del) begin
      if (POS >= pos) begin
        data <= right;
      end
    end
  end

  // Read tap: only the addressed cell can drive a nonzero word
  always_ff @(posedge clk) begin
    tap <= (cop.rd && (POS == pos)) ? data : '0;
  end

endmodule

`default_nettype wire

@@ design/ilid_gather.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ilid_gather import ilid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DATA_W-1:0] taps [CAPACITY],
  output logic      [DATA_W-1:0] total
);

  localparam int NG = (CAPACITY + GROUP - 1) / GROUP;

  logic [DATA_W-1:0] part [NG][GROUP];
  logic [DATA_W-1:0] grp_next [NG];
  logic [DATA_W-1:0] grp [NG];

  // Pick the taps of each group, padding past the last cell
  for (genvar g = 0; g < NG; g++) begin : g_grp
    for (genvar k = 0; k < GROUP; k++) begin : g_tap
      if (g * GROUP + k < CAPACITY) begin : g_live
        assign part[g][k] = taps[g * GROUP + k];
      end else begin : g_pad
        assign part[g][k] = '0;
      end
    end

    always_comb begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        grp_next[g] = grp_next[g] | part[g][k];
      end
    end
  end

  // First tree level, registered
  always_ff @(posedge clk) begin
    if (en) begin
      grp <= grp_next;
    end
  end

  // Second level folds the group words
  always_comb begin
    total = '0;
    for (int g = 0; g < NG; g++) begin
      total = total | grp[g];
    end
  end

endmodule

`default_nettype wire

@@ design/indexed_list_insert_delete.sv @@
// A beat's result passes the cell tap register, the registered group OR,
// and the final OR into the output register. A new beat is taken only when
// the tap and group stages are empty; a result waiting on out_ready holds
// the group stage. Insert and delete shift the cells from the addressed
// position on, in the cycle of acceptance. Reset clears the entry count and
// all valid flags; cells are undefined until written and unread until then.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_delete import ilid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic        [OP_W-1:0]   op,
  input  wire logic signed [IDX_W-1:0]  index,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      read_value,
  output logic        [ST_W-1:0]        status,
  output logic        [LEN_W-1:0]       length
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              acc;
  logic              tap_valid;
  logic              grp_valid;
  logic              out_free;
  logic              rd_ok;
  logic [ST_W-1:0]   st;
  logic [LEN_W-1:0]  len;

  logic              idx_neg;
  logic [XW-1:0]     idx_x;
  logic [XW-1:0]     count_x;
  logic              full;
  logic              rd_ok_next;
  logic [ST_W-1:0]   st_next;
  logic [PW-1:0]     pos;
  cell_op_t          cop;

  logic [DATA_W-1:0] value_u;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] taps [CAPACITY];
  logic [DATA_W-1:0] total;

  assign value_u  = $unsigned(value);
  assign in_ready = !tap_valid && !grp_valid;
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Decode the beat against the current count
  assign idx_neg = index[IDX_W-1];
  assign idx_x   = XW'(index[IDX_W-2:0]);
  assign count_x = XW'(count);
  assign full    = (count == CW'(CAPACITY));

  always_comb begin
    rd_ok_next = 1'b0;
    st_next    = ST_BADIDX;
    pos        = idx_x[PW-1:0];
    cop        = '0;
    count_next = count;
    unique case (op)
      OP_READ: begin
        if (!idx_neg && (idx_x < count_x)) begin
          rd_ok_next = 1'b1;
          st_next    = ST_DONE;
          cop.rd     = 1'b1;
        end
      end
      OP_HEAD, OP_TAIL, OP_BEFORE: begin
        if (op == OP_HEAD || (op == OP_BEFORE && idx_neg)) begin
          pos = '0;
        end else if (op == OP_TAIL) begin
          pos = count[PW-1:0];
        end
        if (op == OP_BEFORE && !idx_neg && (idx_x > count_x)) begin
          st_next = ST_BADIDX;
        end else if (full) begin
          st_next = ST_FULL;
        end else begin
          st_next    = ST_DONE;
          cop.ins    = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_DELETE: begin
        if (!idx_neg && (idx_x < count_x)) begin
          st_next    = ST_DONE;
          cop.del    = 1'b1;
          count_next = count - CW'(1);
        end
      end
      default: begin
        st_next = ST_BADIDX;
      end
    endcase
    if (!acc) begin
      cop        = '0;
      count_next = count;
    end
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = value_u;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    ilid_cell #(
      .PW  (PW),
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .cop   (cop),
      .pos   (pos),
      .value (value_u),
      .left  (left),
      .right (right),
      .data  (cell_data[i]),
      .tap   (taps[i])
    );
  end

  // Read tree
  ilid_gather #(
    .CAPACITY (CAPACITY)
  ) u_gather (
    .clk   (clk),
    .en    (tap_valid),
    .taps  (taps),
    .total (total)
  );

  // Count and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      tap_valid <= 1'b0;
      grp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      tap_valid <= acc;
      if (tap_valid) begin
        grp_valid <= 1'b1;
      end else if (out_free) begin
        grp_valid <= 1'b0;
      end
      if (grp_valid && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result fields held alongside the read path
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_ok <= rd_ok_next;
      st    <= st_next;
      len   <= LEN_W'(count_next);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (grp_valid && out_free) begin
      read_value <= rd_ok ? $signed(total) : '1;
      status     <= st;
      length     <= len;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_tap_to_grp: assert property (@(posedge clk) disable iff (rst)
    tap_valid |=> grp_valid)
    else $error("read tap stage not followed by group stage");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(grp_valid))
    else $error("result shown without a gathered beat");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (acc && cop.ins) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    (acc && cop.del) |=> (count == $past(count) - CW'(1)))
    else $error("delete did not shrink the list by one");

endmodule

`default_nettype wire

@@ tb/sv/tb_indexed_list_insert_delete.sv @@
`timescale 1ns / 1ps

module tb_indexed_list_insert_delete;
  import ilid_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;
  localparam int RUN_LIMIT_NS = 3_000_000;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic        [ST_W-1:0]   status;
    logic        [LEN_W-1:0]  length;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic        [OP_W-1:0]   op = OP_READ;
  logic signed [IDX_W-1:0]  index = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] read_value;
  logic        [ST_W-1:0]   status;
  logic        [LEN_W-1:0]  length;

  // Shadow copy of the list, updated in beat acceptance order
  logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
  int                       list_len = 0;
  list_result_t             pending_results [$];
  int                       err_count = 0;
  bit                       quiet_mode = 1'b0;

  indexed_list_insert_delete #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .index      (index),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .status     (status),
    .length     (length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Apply one operation to the shadow list and return the result it gives
  function automatic list_result_t apply_list_op(logic [OP_W-1:0] code,
                                                 logic signed [IDX_W-1:0] pos_in,
                                                 logic signed [DATA_W-1:0] data);
    list_result_t r;
    int pos;
    int at;
    int k;
    r.read_value = -1;
    r.status     = ST_BADIDX;
    at           = -1;
    pos          = pos_in;
    case (code)
      OP_READ: begin
        if (pos >= 0 && pos < list_len) begin
          r.read_value = list_mem[pos];
          r.status     = ST_DONE;
        end
      end
      OP_HEAD: at = 0;
      OP_TAIL: at = list_len;
      OP_BEFORE: begin
        // negative index means head; past the end is rejected before full check
        if (pos < 0) at = 0;
        else if (pos <= list_len) at = pos;
      end
      OP_DELETE: begin
        if (pos >= 0 && pos < list_len) begin
          for (k = pos; k < list_len - 1; k++) list_mem[k] = list_mem[k + 1];
          list_len--;
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    if (at >= 0) begin
      if (list_len >= LIST_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (k = list_len; k > at; k--) list_mem[k] = list_mem[k - 1];
        list_mem[at] = data;
        list_len++;
        r.status = ST_DONE;
      end
    end
    r.length = LEN_W'(list_len);
    return r;
  endfunction

  // Mostly short idles, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Send one beat after a random gap; predict its result on acceptance
  task automatic send_beat(logic [OP_W-1:0] code, logic signed [IDX_W-1:0] pos,
                           logic signed [DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    index    <= pos;
    value    <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_list_op(code, pos, data));
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Random beat; percentages weight inserts, deletes; else reads or unused ops
  task automatic send_random(int ins_pct, int del_pct);
    int r;
    int pick;
    logic [OP_W-1:0] code;
    logic signed [IDX_W-1:0] pos;
    r   = $urandom_range(0, 99);
    pos = IDX_W'($urandom);
    if (r < ins_pct) begin
      pick = $urandom_range(0, 2);
      code = (pick == 0) ? OP_HEAD : (pick == 1) ? OP_TAIL : OP_BEFORE;
      if ($urandom_range(0, 9) != 0) pos = IDX_W'($urandom_range(0, list_len));
    end else if (r < ins_pct + del_pct) begin
      code = OP_DELETE;
      if (list_len > 0 && $urandom_range(0, 9) != 0)
        pos = IDX_W'($urandom_range(0, list_len - 1));
    end else if (r < 97) begin
      code = OP_READ;
      if (list_len > 0 && $urandom_range(0, 9) != 0)
        pos = IDX_W'($urandom_range(0, list_len - 1));
    end else begin
      // unused op codes
      code = OP_W'($urandom_range(OP_DELETE + 1, (1 << OP_W) - 1));
    end
    send_beat(code, pos, rand_value());
  endtask

  // Ops on the empty list: out of range reads, deletes and inserts
  task automatic test_empty_list();
    send_beat(OP_READ, 9'sd0, rand_value());
    send_beat(OP_DELETE, 9'sd0, rand_value());
    send_beat(OP_BEFORE, 9'sd1, 32'sd5);
    send_beat(OP_W'((1 << OP_W) - 1), 9'sh1FF, -1);
    send_beat(OP_READ, -9'sd256, 32'sd0);
  endtask

  // Every insert flavor, including negative index and past-the-end index
  task automatic test_insert_ops();
    send_beat(OP_HEAD, 9'sd0, 32'sh7FFF_FFFF);
    send_beat(OP_TAIL, 9'sd0, 32'sh8000_0000);
    send_beat(OP_BEFORE, -9'sd1, -1);
    send_beat(OP_BEFORE, 9'sd3, 32'sd0);
    send_beat(OP_BEFORE, 9'sd255, 32'sd77);
    send_beat(OP_BEFORE, 9'sd1, 32'sh5A5A_A5A5);
    send_beat(OP_READ, 9'sd0, 32'sd0);
    send_beat(OP_READ, 9'sd2, 32'sd0);
    send_beat(OP_READ, 9'sd4, 32'sd0);
    send_beat(OP_READ, 9'sd5, 32'sd0);
  endtask

  // Bad deletes, head and tail deletes, unused op codes
  task automatic test_delete_ops();
    send_beat(OP_DELETE, -9'sd1, 32'sd0);
    send_beat(OP_DELETE, 9'sd255, 32'sd0);
    send_beat(OP_DELETE, 9'sd0, 32'sd0);
    send_beat(OP_DELETE, IDX_W'(list_len - 1), 32'sd0);
    send_beat(OP_READ, 9'sd0, 32'sd0);
    send_beat(OP_W'(OP_DELETE + 1), 9'sd0, 32'sd1);
    send_beat(OP_W'(OP_DELETE + 2), 9'sd1, 32'sd2);
  endtask

  // Insert-heavy traffic until the list is full, then hammer the full list
  task automatic test_fill_to_full();
    int guard;
    guard = 0;
    while (list_len < LIST_DEPTH && guard < 250) begin
      send_random(85, 5);
      guard++;
    end
    repeat (12) send_random(70, 0);
  endtask

  // Delete-heavy traffic until the list is empty again
  task automatic test_drain_to_empty();
    int guard;
    guard = 0;
    while (list_len > 0 && guard < 250) begin
      send_random(5, 85);
      guard++;
    end
    repeat (4) send_random(0, 50);
  endtask

  // Balanced traffic, with a back-to-back stretch in the middle
  task automatic test_mixed();
    repeat (110) send_random(40, 35);
    quiet_mode = 1'b1;
    repeat (60) send_random(40, 35);
    quiet_mode = 1'b0;
    repeat (110) send_random(40, 35);
  endtask

  // Result side stalls at random
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      out_ready <= 1'b1;
      hold = $urandom_range(1, 12);
      repeat (hold) @(posedge clk);
      if (!quiet_mode) begin
        hold = pick_gap();
        if (hold > 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  // Compare each result beat against the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat, read_value", read_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.read_value)
          report_mismatch("read_value", read_value, want.read_value);
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (length !== want.length) report_mismatch("length", length, want.length);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    wait_drained();
    test_insert_ops();
    wait_drained();
    test_delete_ops();
    wait_drained();
    test_fill_to_full();
    wait_drained();
    test_drain_to_empty();
    wait_drained();
    test_mixed();
    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
